// ===== hdl/edge_stretch_spring_force_defines.svh =====
// Assertion macros for the edge stretch spring force block.
// Used by the top level only; no other dependencies.
`ifndef EDGE_STRETCH_SPRING_FORCE_DEFINES_SVH
`define EDGE_STRETCH_SPRING_FORCE_DEFINES_SVH

// same-cycle implication
`define ESF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esf assertion failed");

// next-cycle implication
`define ESF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esf assertion failed");

`endif

// ===== hdl/esf_pkg.sv =====
// Shared widths, types and register codes of the edge stretch spring force block.
// No dependencies.
`default_nettype none
package esf_pkg;

   localparam int COORD_W  = 32;
   localparam int MAG_W    = 33;
   localparam int SUM_W    = 66;
   localparam int LEN_W    = 34;
   localparam int TRY_W    = 2 * LEN_W + 1;
   localparam int URW      = LEN_W + 1;
   localparam int FRAC_W   = 16;
   localparam int SE_W     = LEN_W + FRAC_W;
   localparam int U_W      = 33;
   localparam int U_START  = SE_W - U_W;
   localparam int K_W      = 64;
   localparam int A_W      = 95;
   localparam int MID_W    = 65;
   localparam int LO_W     = 98;
   localparam int HI_W     = 97;
   localparam int AF_W     = 129;
   localparam int TOT_W    = 146;
   localparam int F_SHIFT  = 64;
   localparam int F_SAT    = 95;
   localparam int E_SHIFT  = 49;
   localparam int E_SAT    = 81;
   localparam int TAIL_N   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [31:0] FORCE_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] FORCE_MIN  = 32'h8000_0000;
   localparam logic [31:0] ENERGY_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_REST = 2'd0,
      CSR_WEIGHT   = 2'd1,
      CSR_GAIN     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  want;
      logic [COORD_W-1:0]    ref_len;
   } side_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [LEN_W-1:0]      len;
      logic [COORD_W-1:0]    ref_len;
      logic [LEN_W-1:0]      dmag;
      logic [2:0]            neg;
      logic                  se_neg;
      logic                  want;
      logic                  err;
   } div_side_type;

   typedef struct packed {
      logic [SE_W-1:0]       se;
      logic [2:0][U_W-1:0]   u;
      logic [2:0]            neg;
      logic                  se_neg;
      logic                  want;
      logic                  err;
   } tail_type;

endpackage
`default_nettype wire

// ===== hdl/esf_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, sideband carried along.
// Depends on esf_pkg.
`default_nettype none
module esf_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_vld,
   input  logic [esf_pkg::SUM_W-1:0] in_sum,
   input  esf_pkg::side_type         in_side,
   output logic                      out_vld,
   output logic [esf_pkg::LEN_W-1:0] out_root,
   output esf_pkg::side_type         out_side
);
   import esf_pkg::*;

   logic             vld_ff  [LEN_W];
   logic [SUM_W-1:0] rem_ff  [LEN_W];
   logic [LEN_W-1:0] root_ff [LEN_W];
   side_type         side_ff [LEN_W];

   for (genvar s = 0; s < LEN_W; s++) begin : g_stage
      localparam int B = LEN_W - 1 - s;
      logic             cur_vld;
      logic [SUM_W-1:0] cur_rem;
      logic [LEN_W-1:0] cur_root;
      side_type         cur_side;
      logic [TRY_W-1:0] trial;
      logic             fit;
      logic [SUM_W-1:0] rem_in;
      logic [LEN_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign cur_vld  = in_vld;
         assign cur_rem  = in_sum;
         assign cur_root = '0;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_vld  = vld_ff[s-1];
         assign cur_rem  = rem_ff[s-1];
         assign cur_root = root_ff[s-1];
         assign cur_side = side_ff[s-1];
      end

      // root bits below B are zero, so the trial term is an OR
      assign trial   = (TRY_W'(cur_root) << (B + 1)) | (TRY_W'(1) << (2 * B));
      assign fit     = TRY_W'(cur_rem) >= trial;
      assign rem_in  = fit ? (cur_rem - trial[SUM_W-1:0]) : cur_rem;
      assign root_in = fit ? (cur_root | (LEN_W'(1) << B)) : cur_root;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= cur_side;
         end
      end
   end

   assign out_vld  = vld_ff[LEN_W-1];
   assign out_root = root_ff[LEN_W-1];
   assign out_side = side_ff[LEN_W-1];

endmodule
`default_nettype wire

// ===== hdl/esf_div.sv =====
// Pipelined restoring dividers: stretch (dmag << 16) / ref and the three unit
// components (mag << 32) / len, one quotient bit per stage. Depends on esf_pkg.
`default_nettype none
module esf_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_vld,
   input  esf_pkg::div_side_type              in_side,
   output logic                               out_vld,
   output logic [esf_pkg::SE_W-1:0]           out_se,
   output logic [2:0][esf_pkg::U_W-1:0]       out_u,
   output esf_pkg::div_side_type              out_side
);
   import esf_pkg::*;

   logic                    vld_ff  [SE_W];
   logic [COORD_W-1:0]      rse_ff  [SE_W];
   logic [SE_W-1:0]         q_ff    [SE_W];
   logic [2:0][LEN_W-1:0]   ru_ff   [SE_W];
   logic [2:0][U_W-1:0]     u_ff    [SE_W];
   div_side_type            side_ff [SE_W];

   for (genvar s = 0; s < SE_W; s++) begin : g_stage
      localparam int Q = SE_W - 1 - s;
      logic                  cur_vld;
      logic [COORD_W-1:0]    cur_rse;
      logic [SE_W-1:0]       cur_q;
      logic [2:0][LEN_W-1:0] cur_ru;
      logic [2:0][U_W-1:0]   cur_u;
      div_side_type          cur_side;
      logic [SE_W-1:0]       dvd;
      logic [COORD_W:0]      t_se;
      logic [COORD_W:0]      d_se;
      logic                  fit_se;
      logic [COORD_W-1:0]    rse_in;
      logic [SE_W-1:0]       q_in;
      logic [2:0][LEN_W-1:0] ru_in;
      logic [2:0][U_W-1:0]   u_in;

      if (s == 0) begin : g_first
         assign cur_vld  = in_vld;
         assign cur_rse  = '0;
         assign cur_q    = '0;
         assign cur_ru   = '0;
         assign cur_u    = '0;
         assign cur_side = in_side;
      end else begin : g_next
         assign cur_vld  = vld_ff[s-1];
         assign cur_rse  = rse_ff[s-1];
         assign cur_q    = q_ff[s-1];
         assign cur_ru   = ru_ff[s-1];
         assign cur_u    = u_ff[s-1];
         assign cur_side = side_ff[s-1];
      end

      assign dvd    = {cur_side.dmag, FRAC_W'(0)};
      assign t_se   = {cur_rse, dvd[Q]};
      assign d_se   = t_se - {1'b0, cur_side.ref_len};
      assign fit_se = t_se >= {1'b0, cur_side.ref_len};
      assign rse_in = fit_se ? d_se[COORD_W-1:0] : t_se[COORD_W-1:0];
      assign q_in   = fit_se ? (cur_q | (SE_W'(1) << Q)) : cur_q;

      if (s < U_START) begin : g_u_idle
         assign ru_in = '0;
         assign u_in  = '0;
      end else begin : g_u_work
         logic [2:0][URW-1:0] tu;
         logic [2:0][URW-1:0] du;
         logic [2:0]          fu;
         always_comb begin
            for (int j = 0; j < 3; j++) begin
               if (s == U_START) begin
                  tu[j] = URW'(cur_side.mag[j]);
               end else begin
                  tu[j] = {cur_ru[j], 1'b0};
               end
               du[j]    = tu[j] - URW'(cur_side.len);
               fu[j]    = tu[j] >= URW'(cur_side.len);
               ru_in[j] = fu[j] ? du[j][LEN_W-1:0] : tu[j][LEN_W-1:0];
               u_in[j]  = fu[j] ? (cur_u[j] | (U_W'(1) << Q)) : cur_u[j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rse_ff[s]  <= rse_in;
            q_ff[s]    <= q_in;
            ru_ff[s]   <= ru_in;
            u_ff[s]    <= u_in;
            side_ff[s] <= cur_side;
         end
      end
   end

   assign out_vld  = vld_ff[SE_W-1];
   assign out_se   = q_ff[SE_W-1];
   assign out_u    = u_ff[SE_W-1];
   assign out_side = side_ff[SE_W-1];

endmodule
`default_nettype wire

// ===== hdl/edge_stretch_spring_force.sv =====
// Edge stretch spring force: each accepted req beat yields one rsp beat.
// Throughput one edge per cycle: every stage, including the 34-stage square root
// and the 50-stage divider, takes a new beat each cycle; a stall on rsp freezes all stages.
// Reset clears all valid bits and sets use_rest_length=1, weight=gain=1.0.
// Depends on esf_pkg, esf_sqrt, esf_div and edge_stretch_spring_force_defines.svh.
`default_nettype none
`include "edge_stretch_spring_force_defines.svh"
module edge_stretch_spring_force (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // self_x, self_y, self_z, other_x, other_y, other_z, rest_length, mean_length
   input  logic [255:0]                  req_tdata,
   // want_force
   input  logic [0:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // force_dx, force_dy, force_dz, energy
   output logic [127:0]                  rsp_tdata,
   // zero_length_error
   output logic [0:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [esf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import esf_pkg::*;

   logic adv;

   logic               use_rest_ff;
   logic [31:0]        weight_ff;
   logic [31:0]        gain_ff;
   logic [K_W-1:0]     k_ff;

   logic [MAG_W-1:0]   diff [3];
   side_type           f0_side_in;
   logic               f0_vld_ff;
   side_type           f0_side_ff;
   logic               f1_vld_ff;
   side_type           f1_side_ff;
   logic [SUM_W-1:0]   f1_sq_ff [3];
   logic               f2_vld_ff;
   side_type           f2_side_ff;
   logic [SUM_W-1:0]   f2_sum_ff;

   logic               sq_vld;
   logic [LEN_W-1:0]   sq_root;
   side_type           sq_side;
   div_side_type       d0_side_in;
   logic               d0_vld_ff;
   div_side_type       d0_side_ff;

   logic               dv_vld;
   logic [SE_W-1:0]    dv_se;
   logic [2:0][U_W-1:0] dv_u;
   div_side_type       dv_side;
   tail_type           tail_in;

   logic               t_vld_ff  [TAIL_N];
   tail_type           t_tail_ff [TAIL_N];

   logic [63:0]        m1_p_ff [4];
   logic [MID_W-1:0]   m2_mid_ff;
   logic [63:0]        m2_ll_ff;
   logic [63:0]        m2_hh_ff;
   logic [LO_W-1:0]    m3_lo_ff;
   logic [63:0]        m3_hh_ff;
   logic [AF_W-1:0]    a_full;
   logic [A_W-1:0]     m4_a_ff;
   logic               m4_ovf_ff;

   logic [SE_W-1:0]    lm_l1 [4];
   logic [SE_W-1:0]    lm_l4 [4];
   logic [63:0]        l1_p_ff [4][6];
   logic               l1_ovf_ff;
   logic [63:0]        l2_p00_ff  [4];
   logic [MID_W-1:0]   l2_mid1_ff [4];
   logic [MID_W-1:0]   l2_mid2_ff [4];
   logic [63:0]        l2_p21_ff  [4];
   logic               l2_ovf_ff;
   logic [LO_W-1:0]    l3_lo_ff [4];
   logic [HI_W-1:0]    l3_hi_ff [4];
   logic               l3_ovf_ff;
   logic [TOT_W-1:0]   tot [4];
   logic               big_in [4];
   logic [31:0]        val_in [4];
   logic               l4_big_ff [4];
   logic [31:0]        l4_val_ff [4];

   tail_type           tl;
   logic [2:0]         fneg_v;
   logic [2:0][31:0]   mag_v;
   logic [2:0][31:0]   force_v;
   logic [31:0]        energy_v;
   logic               rsp_tvalid_ff;
   logic [127:0]       rsp_tdata_ff;
   logic               rsp_tuser_ff;
   logic               rsp_want_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         use_rest_ff <= 1'b1;
         weight_ff   <= ONE_Q16;
         gain_ff     <= ONE_Q16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_USE_REST: use_rest_ff <= csr_wdata[0];
            CSR_WEIGHT:   weight_ff   <= csr_wdata;
            CSR_GAIN:     gain_ff     <= csr_wdata;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= weight_ff * gain_ff;
   end

   // front: edge vector, squares, sum
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         diff[j] = {req_tdata[(3 + j) * COORD_W + COORD_W - 1],
                    req_tdata[(3 + j) * COORD_W +: COORD_W]}
                 - {req_tdata[j * COORD_W + COORD_W - 1],
                    req_tdata[j * COORD_W +: COORD_W]};
         f0_side_in.neg[j] = diff[j][MAG_W-1];
         f0_side_in.mag[j] = diff[j][MAG_W-1] ? (~diff[j] + 1'b1) : diff[j];
      end
      f0_side_in.want    = req_tuser[0];
      f0_side_in.ref_len = use_rest_ff ? req_tdata[6 * COORD_W +: COORD_W]
                                       : req_tdata[7 * COORD_W +: COORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_vld_ff <= 1'b0;
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         d0_vld_ff <= 1'b0;
      end else if (adv) begin
         f0_vld_ff <= req_tvalid;
         f1_vld_ff <= f0_vld_ff;
         f2_vld_ff <= f1_vld_ff;
         d0_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f0_side_ff <= f0_side_in;
         for (int j = 0; j < 3; j++) begin
            f1_sq_ff[j] <= SUM_W'(f0_side_ff.mag[j]) * SUM_W'(f0_side_ff.mag[j]);
         end
         f1_side_ff <= f0_side_ff;
         f2_sum_ff  <= f1_sq_ff[0] + f1_sq_ff[1] + f1_sq_ff[2];
         f2_side_ff <= f1_side_ff;
         d0_side_ff <= d0_side_in;
      end
   end

   esf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (f2_vld_ff),
      .in_sum   (f2_sum_ff),
      .in_side  (f2_side_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // length against reference
   always_comb begin
      d0_side_in.mag     = sq_side.mag;
      d0_side_in.len     = sq_root;
      d0_side_in.ref_len = sq_side.ref_len;
      d0_side_in.neg     = sq_side.neg;
      d0_side_in.want    = sq_side.want;
      d0_side_in.err     = (sq_root == '0) || (sq_side.ref_len == '0);
      d0_side_in.se_neg  = sq_root < LEN_W'(sq_side.ref_len);
      d0_side_in.dmag    = d0_side_in.se_neg ? (LEN_W'(sq_side.ref_len) - sq_root)
                                             : (sq_root - LEN_W'(sq_side.ref_len));
   end

   esf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (d0_vld_ff),
      .in_side  (d0_side_ff),
      .out_vld  (dv_vld),
      .out_se   (dv_se),
      .out_u    (dv_u),
      .out_side (dv_side)
   );

   always_comb begin
      tail_in.se     = dv_se;
      tail_in.u      = dv_u;
      tail_in.neg    = dv_side.neg;
      tail_in.se_neg = dv_side.se_neg;
      tail_in.want   = dv_side.want;
      tail_in.err    = dv_side.err;
   end

   // tail sideband and valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAIL_N; i++) begin
            t_vld_ff[i] <= 1'b0;
         end
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         t_vld_ff[0] <= dv_vld;
         for (int i = 1; i < TAIL_N; i++) begin
            t_vld_ff[i] <= t_vld_ff[i-1];
         end
         rsp_tvalid_ff <= t_vld_ff[TAIL_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_tail_ff[0] <= tail_in;
         for (int i = 1; i < TAIL_N; i++) begin
            t_tail_ff[i] <= t_tail_ff[i-1];
         end
      end
   end

   // A = k * se in partial products
   assign a_full = AF_W'(m3_lo_ff) + (AF_W'(m3_hh_ff) << 64);

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_p_ff[0] <= 64'(k_ff[31:0])  * 64'(dv_se[31:0]);
         m1_p_ff[1] <= 64'(k_ff[31:0])  * 64'(dv_se[SE_W-1:32]);
         m1_p_ff[2] <= 64'(k_ff[63:32]) * 64'(dv_se[31:0]);
         m1_p_ff[3] <= 64'(k_ff[63:32]) * 64'(dv_se[SE_W-1:32]);
         m2_mid_ff  <= MID_W'(m1_p_ff[1]) + MID_W'(m1_p_ff[2]);
         m2_ll_ff   <= m1_p_ff[0];
         m2_hh_ff   <= m1_p_ff[3];
         m3_lo_ff   <= LO_W'(m2_ll_ff) + (LO_W'(m2_mid_ff) << 32);
         m3_hh_ff   <= m2_hh_ff;
         m4_a_ff    <= a_full[A_W-1:0];
         m4_ovf_ff  <= |a_full[AF_W-1:A_W];
      end
   end

   // lanes: three force axes times u, energy times se
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (j < 3) begin
            lm_l1[j] = SE_W'(t_tail_ff[3].u[j]);
            lm_l4[j] = SE_W'(t_tail_ff[6].u[j]);
         end else begin
            lm_l1[j] = t_tail_ff[3].se;
            lm_l4[j] = t_tail_ff[6].se;
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         tot[j] = TOT_W'(l3_lo_ff[j]) + (TOT_W'(l3_hi_ff[j]) << 64);
         if (j < 3) begin
            big_in[j] = (|tot[j][TOT_W-1:F_SAT]) || (l3_ovf_ff && (lm_l4[j] != '0));
            val_in[j] = tot[j][F_SAT:F_SHIFT];
         end else begin
            big_in[j] = (|tot[j][TOT_W-1:E_SAT]) || (l3_ovf_ff && (lm_l4[j] != '0));
            val_in[j] = tot[j][E_SAT-1:E_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            l1_p_ff[j][0] <= 64'(m4_a_ff[31:0])    * 64'(lm_l1[j][31:0]);
            l1_p_ff[j][1] <= 64'(m4_a_ff[31:0])    * 64'(lm_l1[j][SE_W-1:32]);
            l1_p_ff[j][2] <= 64'(m4_a_ff[63:32])   * 64'(lm_l1[j][31:0]);
            l1_p_ff[j][3] <= 64'(m4_a_ff[63:32])   * 64'(lm_l1[j][SE_W-1:32]);
            l1_p_ff[j][4] <= 64'(m4_a_ff[A_W-1:64]) * 64'(lm_l1[j][31:0]);
            l1_p_ff[j][5] <= 64'(m4_a_ff[A_W-1:64]) * 64'(lm_l1[j][SE_W-1:32]);
            l2_p00_ff[j]  <= l1_p_ff[j][0];
            l2_mid1_ff[j] <= MID_W'(l1_p_ff[j][1]) + MID_W'(l1_p_ff[j][2]);
            l2_mid2_ff[j] <= MID_W'(l1_p_ff[j][3]) + MID_W'(l1_p_ff[j][4]);
            l2_p21_ff[j]  <= l1_p_ff[j][5];
            l3_lo_ff[j]   <= LO_W'(l2_p00_ff[j]) + (LO_W'(l2_mid1_ff[j]) << 32);
            l3_hi_ff[j]   <= HI_W'(l2_mid2_ff[j]) + (HI_W'(l2_p21_ff[j]) << 32);
            l4_big_ff[j]  <= big_in[j];
            l4_val_ff[j]  <= val_in[j];
         end
         l1_ovf_ff <= m4_ovf_ff;
         l2_ovf_ff <= l1_ovf_ff;
         l3_ovf_ff <= l2_ovf_ff;
      end
   end

   // saturation, sign and masking
   assign tl = t_tail_ff[TAIL_N-1];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         fneg_v[j] = tl.se_neg ^ tl.neg[j];
         mag_v[j]  = {1'b0, l4_val_ff[j][30:0]};
         if (tl.err || !tl.want) begin
            force_v[j] = '0;
         end else if (l4_big_ff[j]) begin
            force_v[j] = fneg_v[j] ? FORCE_MIN : FORCE_MAX;
         end else begin
            force_v[j] = fneg_v[j] ? (~mag_v[j] + 1'b1) : mag_v[j];
         end
      end
      if (tl.err) begin
         energy_v = '0;
      end else if (l4_big_ff[3]) begin
         energy_v = ENERGY_MAX;
      end else begin
         energy_v = l4_val_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {energy_v, force_v[2], force_v[1], force_v[0]};
         rsp_tuser_ff <= tl.err;
         rsp_want_ff  <= tl.want;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

   `ESF_ASSERT_IMPL(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `ESF_ASSERT_IMPL(a_no_force, clock, reset, rsp_tvalid && !rsp_want_ff, rsp_tdata[95:0] == '0)
   `ESF_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(t_vld_ff[TAIL_N-1]))

endmodule
`default_nettype wire
